// File: src/i2cmrt_pkg.sv
// Package with the item modes, bus status codes and outcome codes of the I2C register sequencer.
`timescale 1ns / 1ps

package i2cmrt_pkg;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_START  = 2'd1,
		MODE_STATUS = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OUTCOME_NONE     = 2'd0,
		OUTCOME_COMPLETE = 2'd1,
		OUTCOME_ABORT    = 2'd2
	} outcome_t;

	localparam logic [7:0] STATUS_MASK    = 8'hF8;
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RESTART     = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
	localparam logic [7:0] ST_DATA_TX_ACK = 8'h28;
	localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
	localparam logic [7:0] ST_DATA_RX_ACK = 8'h50;
	localparam logic [7:0] ST_DATA_RX_NAK = 8'h58;

endpackage

// File: src/i2c_master_register_transfer.sv
// Top level of the I2C master register transfer sequencer.
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle unless stalled; a held result stalls a full input register.
// The transaction state and the data buffer are updated as an item leaves the input register.
// Reset (arst_n low, asynchronous) clears the transaction state, the data buffer and both valids.
`timescale 1ns / 1ps

module i2c_master_register_transfer
	import i2cmrt_pkg::*;
#(
	parameter int BUFFER_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic       direction,
	input  logic [7:0] slave_address,
	input  logic [7:0] register_address,
	input  logic [3:0] byte_count,
	input  logic [2:0] buffer_index,
	input  logic [7:0] write_byte,
	input  logic [7:0] bus_status,
	input  logic [7:0] received_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       tx_load,
	output logic       issue_start,
	output logic       issue_stop,
	output logic       ack_next,
	output logic       busy_res,
	output logic [1:0] outcome,
	output logic       rd_valid,
	output logic [2:0] rd_index,
	output logic [7:0] rd_byte
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int PW = $clog2(BUFFER_DEPTH + 1);

	// Input register
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic       direction_s1;
	logic [7:0] slave_address_s1;
	logic [7:0] register_address_s1;
	logic [3:0] byte_count_s1;
	logic [2:0] buffer_index_s1;
	logic [7:0] write_byte_s1;
	logic [7:0] bus_status_s1;
	logic [7:0] received_byte_s1;

	// Transaction state
	logic          active_q;
	logic          is_read_q;
	logic [7:0]    target_address_q;
	logic [7:0]    target_register_q;
	logic [3:0]    transfer_count_q;
	logic [PW-1:0] position_q;
	logic [7:0]    data_buffer_q [BUFFER_DEPTH];

	logic advance;
	logic in_accept;

	assign advance   = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1             <= mode;
			direction_s1        <= direction;
			slave_address_s1    <= slave_address;
			register_address_s1 <= register_address;
			byte_count_s1       <= byte_count;
			buffer_index_s1     <= buffer_index;
			write_byte_s1       <= write_byte;
			bus_status_s1       <= bus_status;
			received_byte_s1    <= received_byte;
		end
	end

	// Work for the item held in the input register
	logic          process;
	logic [7:0]    status_m;
	logic          pos_in_buf;
	logic [AW-1:0] pos_addr;
	logic [PW-1:0] pos_inc;
	logic [3:0]    count_sat;

	logic          active_d;
	logic          is_read_d;
	logic [7:0]    target_address_d;
	logic [7:0]    target_register_d;
	logic [3:0]    transfer_count_d;
	logic [PW-1:0] position_d;
	logic          buf_we;
	logic [AW-1:0] buf_waddr;
	logic [7:0]    buf_wdata;

	logic [7:0] tx_byte_c;
	logic       tx_load_c;
	logic       issue_start_c;
	logic       issue_stop_c;
	logic       ack_next_c;
	outcome_t   outcome_c;
	logic       rd_valid_c;
	logic [2:0] rd_index_c;
	logic [7:0] rd_byte_c;

	assign process    = valid_s1 && advance;
	assign status_m   = bus_status_s1 & STATUS_MASK;
	assign pos_in_buf = 32'(position_q) < BUFFER_DEPTH;
	assign pos_addr   = AW'(32'(position_q));
	assign pos_inc    = position_q + PW'(1);
	assign count_sat  = (32'(byte_count_s1) > BUFFER_DEPTH) ?
		4'(BUFFER_DEPTH) : byte_count_s1;

	always_comb begin
		active_d          = active_q;
		is_read_d         = is_read_q;
		target_address_d  = target_address_q;
		target_register_d = target_register_q;
		transfer_count_d  = transfer_count_q;
		position_d        = position_q;
		buf_we            = 1'b0;
		buf_waddr         = pos_addr;
		buf_wdata         = received_byte_s1;

		tx_byte_c     = 8'd0;
		tx_load_c     = 1'b0;
		issue_start_c = 1'b0;
		issue_stop_c  = 1'b0;
		ack_next_c    = 1'b0;
		outcome_c     = OUTCOME_NONE;
		rd_valid_c    = 1'b0;
		rd_index_c    = 3'd0;
		rd_byte_c     = 8'd0;

		unique case (mode_t'(mode_s1))
			MODE_LOAD: begin
				if (32'(buffer_index_s1) < BUFFER_DEPTH) begin
					buf_we    = 1'b1;
					buf_waddr = AW'(32'(buffer_index_s1));
					buf_wdata = write_byte_s1;
				end
			end
			MODE_START: begin
				active_d          = 1'b1;
				is_read_d         = direction_s1;
				target_address_d  = slave_address_s1;
				target_register_d = register_address_s1;
				transfer_count_d  = count_sat;
				position_d        = '0;
				issue_start_c     = 1'b1;
			end
			MODE_STATUS: begin
				if (active_q) begin
					unique case (status_m)
						ST_START: begin
							tx_byte_c = target_address_q;
							tx_load_c = 1'b1;
						end
						ST_RESTART: begin
							tx_byte_c = target_address_q + {7'd0, is_read_q};
							tx_load_c = 1'b1;
						end
						ST_SLAW_ACK: begin
							tx_byte_c = target_register_q;
							tx_load_c = 1'b1;
						end
						ST_DATA_TX_ACK: begin
							if (is_read_q) begin
								issue_start_c = 1'b1;
							end else if (32'(position_q) < 32'(transfer_count_q) && pos_in_buf) begin
								tx_byte_c  = data_buffer_q[pos_addr];
								tx_load_c  = 1'b1;
								position_d = pos_inc;
							end else begin
								issue_stop_c = 1'b1;
								outcome_c    = OUTCOME_COMPLETE;
								active_d     = 1'b0;
							end
						end
						ST_SLAR_ACK: begin
							ack_next_c = transfer_count_q > 4'd1;
						end
						ST_DATA_RX_ACK: begin
							if (!pos_in_buf) begin
								issue_stop_c = 1'b1;
								outcome_c    = OUTCOME_COMPLETE;
								active_d     = 1'b0;
							end else begin
								buf_we     = 1'b1;
								rd_valid_c = 1'b1;
								rd_index_c = 3'(32'(position_q));
								rd_byte_c  = received_byte_s1;
								position_d = pos_inc;
								if (32'(pos_inc) >= 32'(transfer_count_q) ||
								    32'(pos_inc) >= BUFFER_DEPTH) begin
									issue_stop_c = 1'b1;
									outcome_c    = OUTCOME_COMPLETE;
									active_d     = 1'b0;
								end else begin
									ack_next_c = transfer_count_q > 4'd1;
								end
							end
						end
						ST_DATA_RX_NAK: begin
							if (pos_in_buf) begin
								buf_we     = 1'b1;
								rd_valid_c = 1'b1;
								rd_index_c = 3'(32'(position_q));
								rd_byte_c  = received_byte_s1;
							end
							issue_stop_c = 1'b1;
							outcome_c    = OUTCOME_COMPLETE;
							active_d     = 1'b0;
						end
						default: begin
							issue_stop_c = 1'b1;
							outcome_c    = OUTCOME_ABORT;
							active_d     = 1'b0;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q          <= 1'b0;
			is_read_q         <= 1'b0;
			target_address_q  <= 8'd0;
			target_register_q <= 8'd0;
			transfer_count_q  <= 4'd0;
			position_q        <= '0;
			for (int i = 0; i < BUFFER_DEPTH; i++) begin
				data_buffer_q[i] <= 8'd0;
			end
		end else if (process) begin
			active_q          <= active_d;
			is_read_q         <= is_read_d;
			target_address_q  <= target_address_d;
			target_register_q <= target_register_d;
			transfer_count_q  <= transfer_count_d;
			position_q        <= position_d;
			if (buf_we) begin
				data_buffer_q[buf_waddr] <= buf_wdata;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			tx_byte     <= tx_byte_c;
			tx_load     <= tx_load_c;
			issue_start <= issue_start_c;
			issue_stop  <= issue_stop_c;
			ack_next    <= ack_next_c;
			busy_res    <= active_d;
			outcome     <= outcome_c;
			rd_valid    <= rd_valid_c;
			rd_index    <= rd_index_c;
			rd_byte     <= rd_byte_c;
		end
	end

endmodule
